FILE: src/bssh_pkg.sv
// Package for the bit-scan shift hash block.
// Holds the state widths, the configuration register map and the config bundle type.
// Used by every file in src; has no dependencies.
package bssh_pkg;

  localparam int HALF_W    = 64;
  localparam int HASH_W    = 2 * HALF_W;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int AMT_W     = 8;

  typedef logic [HASH_W-1:0]    hash_t;
  typedef logic [HALF_W-1:0]    half_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [AMT_W-1:0]     amt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_LOW       = 3'd0,
    REG_INIT_HIGH      = 3'd1,
    REG_POLY_ZERO_LOW  = 3'd2,
    REG_POLY_ZERO_HIGH = 3'd3,
    REG_POLY_ONE_LOW   = 3'd4,
    REG_POLY_ONE_HIGH  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    hash_t init;
    hash_t poly_zero;
    hash_t poly_one;
  } cfg_t;

  // Shift that drops the lowest set bit and everything below it.
  // An all-zero value gives a full shift, which clears the word.
  function automatic amt_t drop_amount(input hash_t x);
    amt_t amt;
    amt = amt_t'(HASH_W);
    for (int i = HASH_W - 1; i >= 0; i--) begin
      if (x[i]) begin
        amt = amt_t'(i + 1);
      end
    end
    return amt;
  endfunction

endpackage

FILE: src/bssh_if.sv
// Valid/ready channel interfaces for the bit-scan shift hash block.
// Depends on bssh_pkg for the payload types.
interface bssh_in_if;
  logic               valid;
  logic               ready;
  bssh_pkg::byte_t    data_byte;
  logic               start_req;
  logic               final_byte;

  modport source (output valid, output data_byte, output start_req, output final_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input start_req, input final_byte,
                  output ready);
endinterface

interface bssh_out_if;
  logic               valid;
  logic               ready;
  bssh_pkg::half_t    hash_low;
  bssh_pkg::half_t    hash_high;
  logic               is_final;

  modport source (output valid, output hash_low, output hash_high, output is_final,
                  input ready);
  modport sink   (input valid, input hash_low, input hash_high, input is_final,
                  output ready);
endinterface

FILE: src/bit_scan_shift_hash_top.sv
// Bit-scan shift hash: 128-bit state updated once per message byte.
// Input channel in_ch carries data_byte, start_req and final_byte; output
// channel out_ch carries hash_low, hash_high and is_final for each request.
// Each bit of a byte, LSB first, shifts the state right past its lowest set
// bit and XORs in poly_zero or poly_one. start_req reloads the init value
// before the byte; final_byte is passed through as is_final.
// Configuration: cfg_we, cfg_index (0..5) and cfg_data (64 bits) write one
// register half per cycle; write only while the block is idle.
// Result: registered, valid at out_ch in the cycle after acceptance.
// Throughput: one byte per cycle; the eight bit steps form one combinational
// pass from the state register to the state and result registers.
// Stall: a held result keeps in_ch.ready low; ready returns in the cycle the
// receiver takes the result, so a new request can enter at the same edge.
// Reset: synchronous, active high; clears the state, the configuration
// registers and the output valid.
// Depends on bssh_pkg, bssh_if, bssh_cfg_regs and bssh_round.
module bit_scan_shift_hash_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  bssh_pkg::cfg_idx_t  cfg_index,
  input  bssh_pkg::half_t     cfg_data,
  bssh_in_if.sink             in_ch,
  bssh_out_if.source          out_ch
);

  bssh_pkg::cfg_t  cfg;
  bssh_pkg::hash_t state;
  bssh_pkg::hash_t base;
  bssh_pkg::hash_t state_next;
  bssh_pkg::hash_t hash_out;
  logic            final_out;
  logic            out_valid;
  logic            accept;

  bssh_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign base = in_ch.start_req ? cfg.init : state;

  bssh_round u_round (
    .state_in  (base),
    .data_byte (in_ch.data_byte),
    .poly_zero (cfg.poly_zero),
    .poly_one  (cfg.poly_one),
    .state_out (state_next)
  );

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hash_out  <= state_next;
      final_out <= in_ch.final_byte;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.hash_low  = hash_out[bssh_pkg::HALF_W-1:0];
  assign out_ch.hash_high = hash_out[bssh_pkg::HASH_W-1:bssh_pkg::HALF_W];
  assign out_ch.is_final  = final_out;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    !rst && accept |=> out_ch.valid)
    else $error("accepted request produced no result");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while result stalled");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    !rst && accept |=> hash_out == state)
    else $error("result differs from running state");

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (rst)
    !rst && !accept |=> $stable(state))
    else $error("state changed without a request");

  a_held_result_stable: assert property (@(posedge clk) disable iff (rst)
    !rst && out_ch.valid && !out_ch.ready |=> $stable(hash_out) && $stable(final_out))
    else $error("stalled result changed");

endmodule

FILE: src/bssh_cfg_regs.sv
// Configuration register file: initial state and the two XOR polynomials.
// Depends on bssh_pkg for the register map and the cfg_t bundle.
module bssh_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  bssh_pkg::cfg_idx_t  cfg_index,
  input  bssh_pkg::half_t     cfg_data,
  output bssh_pkg::cfg_t      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bssh_pkg::REG_INIT_LOW:       cfg.init[bssh_pkg::HALF_W-1:0]                  <= cfg_data;
        bssh_pkg::REG_INIT_HIGH:      cfg.init[bssh_pkg::HASH_W-1:bssh_pkg::HALF_W]   <= cfg_data;
        bssh_pkg::REG_POLY_ZERO_LOW:  cfg.poly_zero[bssh_pkg::HALF_W-1:0]             <= cfg_data;
        bssh_pkg::REG_POLY_ZERO_HIGH:
          cfg.poly_zero[bssh_pkg::HASH_W-1:bssh_pkg::HALF_W] <= cfg_data;
        bssh_pkg::REG_POLY_ONE_LOW:   cfg.poly_one[bssh_pkg::HALF_W-1:0]              <= cfg_data;
        bssh_pkg::REG_POLY_ONE_HIGH:
          cfg.poly_one[bssh_pkg::HASH_W-1:bssh_pkg::HALF_W] <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

FILE: src/bssh_bit_step.sv
// One bit step: drop the lowest set bit of the state with all bits below it,
// then XOR in the polynomial picked by the message bit. Depends on bssh_pkg.
module bssh_bit_step (
  input  bssh_pkg::hash_t  state_in,
  input  logic             msg_bit,
  input  bssh_pkg::hash_t  poly_zero,
  input  bssh_pkg::hash_t  poly_one,
  output bssh_pkg::hash_t  state_out
);

  bssh_pkg::amt_t  amt;
  bssh_pkg::hash_t shifted;

  always_comb begin
    amt       = bssh_pkg::drop_amount(state_in);
    shifted   = state_in >> amt;  // amount of 128 clears the word
    state_out = shifted ^ (msg_bit ? poly_one : poly_zero);
  end

endmodule

FILE: src/bssh_round.sv
// Byte round: eight chained bit steps, message bits taken LSB first.
// Depends on bssh_pkg and bssh_bit_step.
module bssh_round (
  input  bssh_pkg::hash_t  state_in,
  input  bssh_pkg::byte_t  data_byte,
  input  bssh_pkg::hash_t  poly_zero,
  input  bssh_pkg::hash_t  poly_one,
  output bssh_pkg::hash_t  state_out
);

  bssh_pkg::hash_t chain [bssh_pkg::BYTE_W+1];

  assign chain[0] = state_in;

  for (genvar j = 0; j < bssh_pkg::BYTE_W; j++) begin : g_step
    bssh_bit_step u_step (
      .state_in  (chain[j]),
      .msg_bit   (data_byte[j]),
      .poly_zero (poly_zero),
      .poly_one  (poly_one),
      .state_out (chain[j+1])
    );
  end

  assign state_out = chain[bssh_pkg::BYTE_W];

endmodule

FILE: sim/tb.sv
// Testbench for bit_scan_shift_hash_top: drives hash requests and config writes,
// predicts each 128-bit hash result and checks it field by field.
// Depends on bssh_pkg, bssh_if and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bssh_pkg::cfg_idx_t IDX_SPARE_LOW  = 3'd6;
  localparam bssh_pkg::cfg_idx_t IDX_SPARE_HIGH = 3'd7;

  typedef struct {
    bssh_pkg::half_t lo;
    bssh_pkg::half_t hi;
    logic            fin;
  } hash_result_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  bssh_pkg::cfg_idx_t cfg_index;
  bssh_pkg::half_t    cfg_data;

  bssh_in_if  in_ch();
  bssh_out_if out_ch();

  bit_scan_shift_hash_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  bssh_pkg::hash_t cfg_init;
  bssh_pkg::hash_t cfg_poly_zero;
  bssh_pkg::hash_t cfg_poly_one;
  bssh_pkg::hash_t running_hash;
  hash_result_t    pending_hashes[$];
  int              mismatches = 0;
  bit              idle_on;
  int              stall_left = 0;

  always #5 clk = ~clk;

  // Eight bit steps, LSB first: drop the lowest set bit and all below, then
  // fold in the polynomial picked by the bit. A zero state shifts to zero.
  function automatic bssh_pkg::hash_t hash_after_byte(bssh_pkg::hash_t st,
                                                      bssh_pkg::byte_t b);
    for (int j = 0; j < bssh_pkg::BYTE_W; j++) begin
      if (st != '0) begin
        while (!st[0]) st = st >> 1;
      end
      st = st >> 1;
      st = st ^ (b[j] ? cfg_poly_one : cfg_poly_zero);
    end
    return st;
  endfunction

  function automatic bssh_pkg::half_t rand_half();
    bssh_pkg::half_t v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = v << $urandom_range(0, 63);
      3: v = bssh_pkg::half_t'(1) << $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  task automatic write_reg(bssh_pkg::cfg_idx_t idx, bssh_pkg::half_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      bssh_pkg::REG_INIT_LOW:
        cfg_init[bssh_pkg::HALF_W-1:0] = value;
      bssh_pkg::REG_INIT_HIGH:
        cfg_init[bssh_pkg::HASH_W-1:bssh_pkg::HALF_W] = value;
      bssh_pkg::REG_POLY_ZERO_LOW:
        cfg_poly_zero[bssh_pkg::HALF_W-1:0] = value;
      bssh_pkg::REG_POLY_ZERO_HIGH:
        cfg_poly_zero[bssh_pkg::HASH_W-1:bssh_pkg::HALF_W] = value;
      bssh_pkg::REG_POLY_ONE_LOW:
        cfg_poly_one[bssh_pkg::HALF_W-1:0] = value;
      bssh_pkg::REG_POLY_ONE_HIGH:
        cfg_poly_one[bssh_pkg::HASH_W-1:bssh_pkg::HALF_W] = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_hash(bssh_pkg::cfg_idx_t low_idx, bssh_pkg::cfg_idx_t high_idx,
                            bssh_pkg::hash_t value);
    write_reg(low_idx, value[bssh_pkg::HALF_W-1:0]);
    write_reg(high_idx, value[bssh_pkg::HASH_W-1:bssh_pkg::HALF_W]);
  endtask

  task automatic send_byte(bssh_pkg::byte_t b, logic s, logic f);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.start_req  <= s;
    in_ch.final_byte <= f;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (s) running_hash = cfg_init;
    running_hash = hash_after_byte(running_hash, b);
    pending_hashes.push_back('{running_hash[bssh_pkg::HALF_W-1:0],
                               running_hash[bssh_pkg::HASH_W-1:bssh_pkg::HALF_W], f});
  endtask

  // Drop valid and let every outstanding request drain before touching config.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic report(string field, bssh_pkg::half_t want, bssh_pkg::half_t got);
    mismatches++;
    $display("%0t: %s expected %h got %h", $time, field, want, got);
  endtask

  // Output side: random stall before taking each result when idle_on is set.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    hash_result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      stall_left = idle_on ? $urandom_range(0, 5) : 0;
      if (pending_hashes.size() == 0) begin
        report("unexpected hash_low", '0, out_ch.hash_low);
      end else begin
        want = pending_hashes.pop_front();
        if (out_ch.hash_low !== want.lo) report("hash_low", want.lo, out_ch.hash_low);
        if (out_ch.hash_high !== want.hi) report("hash_high", want.hi, out_ch.hash_high);
        if (out_ch.is_final !== want.fin)
          report("is_final", bssh_pkg::half_t'(want.fin),
                 bssh_pkg::half_t'(out_ch.is_final));
      end
    end
  end

  task automatic test_after_reset();
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'hA5, 1'b0, 1'b0);
    settle();
  endtask

  task automatic test_register_map();
    write_hash(bssh_pkg::REG_INIT_LOW, bssh_pkg::REG_INIT_HIGH,
               128'h0123_4567_89AB_CDEF_FEDC_BA98_7654_3210);
    write_hash(bssh_pkg::REG_POLY_ZERO_LOW, bssh_pkg::REG_POLY_ZERO_HIGH,
               128'hDEAD_BEEF_0000_1111_2222_3333_4444_5550);
    write_hash(bssh_pkg::REG_POLY_ONE_LOW, bssh_pkg::REG_POLY_ONE_HIGH,
               128'h8000_0000_0000_0001_0F0F_0F0F_F0F0_F0F0);
    // spare indexes must not land anywhere
    write_reg(IDX_SPARE_LOW, '1);
    write_reg(IDX_SPARE_HIGH, '1);
    send_byte(8'h3C, 1'b1, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b1);
    settle();
    // new init only counts from the next start; final byte keeps the state
    write_hash(bssh_pkg::REG_INIT_LOW, bssh_pkg::REG_INIT_HIGH,
               128'h5555_AAAA_5555_AAAA_0000_0000_0000_0080);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b1);
    settle();
  endtask

  task automatic test_shift_edges();
    write_hash(bssh_pkg::REG_POLY_ZERO_LOW, bssh_pkg::REG_POLY_ZERO_HIGH,
               bssh_pkg::hash_t'(1) << (bssh_pkg::HASH_W - 1));
    write_hash(bssh_pkg::REG_POLY_ONE_LOW, bssh_pkg::REG_POLY_ONE_HIGH,
               (bssh_pkg::hash_t'(1) << bssh_pkg::HALF_W) | (bssh_pkg::hash_t'(1) << 63));
    write_hash(bssh_pkg::REG_INIT_LOW, bssh_pkg::REG_INIT_HIGH,
               bssh_pkg::hash_t'(1) << (bssh_pkg::HASH_W - 1));
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    settle();
    write_hash(bssh_pkg::REG_INIT_LOW, bssh_pkg::REG_INIT_HIGH,
               bssh_pkg::hash_t'(1) << 63);
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'h01, 1'b1, 1'b1);
    settle();
    write_hash(bssh_pkg::REG_INIT_LOW, bssh_pkg::REG_INIT_HIGH,
               bssh_pkg::hash_t'(1) << bssh_pkg::HALF_W);
    send_byte(8'h5A, 1'b1, 1'b1);
    settle();
  endtask

  task automatic test_extreme_values();
    write_hash(bssh_pkg::REG_INIT_LOW, bssh_pkg::REG_INIT_HIGH, '1);
    write_hash(bssh_pkg::REG_POLY_ZERO_LOW, bssh_pkg::REG_POLY_ZERO_HIGH, '1);
    write_hash(bssh_pkg::REG_POLY_ONE_LOW, bssh_pkg::REG_POLY_ONE_HIGH, '1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b1);
    settle();
    write_hash(bssh_pkg::REG_POLY_ZERO_LOW, bssh_pkg::REG_POLY_ZERO_HIGH, '0);
    write_hash(bssh_pkg::REG_POLY_ONE_LOW, bssh_pkg::REG_POLY_ONE_HIGH, '0);
    send_byte(8'hAA, 1'b1, 1'b0);
    send_byte(8'h7F, 1'b1, 1'b1);
    settle();
  endtask

  task automatic test_random_messages();
    int sent;
    int len;
    for (int phase = 0; phase < 12; phase++) begin
      settle();
      idle_on = (phase % 4) != 3;
      for (int r = 0; r < 6; r++) write_reg(bssh_pkg::cfg_idx_t'(r), rand_half());
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? IDX_SPARE_LOW : IDX_SPARE_HIGH, rand_half());
      sent = 0;
      while (sent < 120) begin
        if ($urandom_range(0, 9) < 8) begin
          len = $urandom_range(1, 12);
          for (int k = 0; k < len; k++)
            send_byte(bssh_pkg::byte_t'($urandom), k == 0, k == len - 1);
          sent += len;
        end else begin
          send_byte(bssh_pkg::byte_t'($urandom), 1'(($urandom_range(0, 3) == 0)),
                    1'($urandom));
          sent++;
        end
      end
    end
    settle();
  endtask

  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.start_req  = 1'b0;
    in_ch.final_byte = 1'b0;
    cfg_init         = '0;
    cfg_poly_zero    = '0;
    cfg_poly_one     = '0;
    running_hash     = '0;
    idle_on          = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_register_map();
    test_shift_edges();
    test_extreme_values();
    test_random_messages();

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: bit_scan_shift_hash_top.f
src/bssh_pkg.sv
src/bssh_if.sv
src/bssh_cfg_regs.sv
src/bssh_bit_step.sv
src/bssh_round.sv
src/bit_scan_shift_hash_top.sv
sim/tb.sv
